// ===== hdl/shb_pkg.sv =====
package shb_pkg;

	// default sizing
	localparam int NUM_BINS_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 32;

	// widest bin address carried in the queue (NUM_BINS up to 65536)
	localparam int MAX_BIN_BITS = 16;
	// quotient bits produced by the divider
	localparam int DIV_BITS     = 32;
	localparam int OUT_IDX_MAX  = 1023;

	// register indexes (decoded from paddr[2])
	localparam logic REG_BIN_WIDTH   = 1'b0;
	localparam logic REG_BINS_IN_USE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_COUNTED = 2'd0,
		ST_DROPPED = 2'd1,
		ST_READ    = 2'd2
	} status_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_ADD,
		OP_DROP,
		OP_READ,
		OP_READ_ZERO
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic                      side;
		logic [MAX_BIN_BITS-1:0]   bin;
		logic [9:0]                idx;
		logic [15:0]               weight;
	} qentry_t;

endpackage

// ===== hdl/shb_req_if.sv =====
interface shb_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] value;
	logic        [15:0] weight;
	logic               read_negative;
	logic        [9:0]  read_index;

	modport source (output valid, func, value, weight, read_negative, read_index,
		input ready);
	modport sink (input valid, func, value, weight, read_negative, read_index,
		output ready);
endinterface

// ===== hdl/shb_rsp_if.sv =====
interface shb_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] count;
	logic        side;
	logic [9:0]  bin_index;

	modport source (output valid, status, count, side, bin_index, input ready);
	modport sink (input valid, status, count, side, bin_index, output ready);
endinterface

// ===== hdl/shb_ram.sv =====
module shb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/shb_front.sv =====
module shb_front #(
	parameter int NUM_BINS = shb_pkg::NUM_BINS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	shb_req_if.sink           req,
	input  logic              clearing,
	input  logic [31:0]       bin_width,
	input  logic [10:0]       bins_in_use,
	output logic              push,
	output shb_pkg::qentry_t  push_data,
	input  logic              full
);
	localparam int STEP_W = $clog2(shb_pkg::DIV_BITS);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t                       state_q;
	logic [shb_pkg::DIV_BITS:0]    rem_q;
	logic [shb_pkg::DIV_BITS-1:0]  mag_q;
	logic [shb_pkg::DIV_BITS-1:0]  quot_q;
	logic [31:0]                   div_q;
	logic [STEP_W-1:0]             step_q;
	shb_pkg::qentry_t              entry_q;

	logic [shb_pkg::DIV_BITS:0]    rem_sh;
	logic                          qbit;
	logic [shb_pkg::DIV_BITS-1:0]  quot_nx;
	logic [31:0]                   limit;
	logic [31:0]                   idx_ext;
	logic [31:0]                   neg_mag;

	assign req.ready = (state_q == F_IDLE) && !clearing;
	assign push      = (state_q == F_PUSH) && !full;
	assign push_data = entry_q;

	// one restoring division step per cycle
	always_comb begin
		rem_sh  = {rem_q[shb_pkg::DIV_BITS-1:0], mag_q[shb_pkg::DIV_BITS-1]};
		qbit    = (rem_sh >= {1'b0, div_q});
		quot_nx = {quot_q[shb_pkg::DIV_BITS-2:0], qbit};
		limit   = (32'(bins_in_use) > 32'(NUM_BINS)) ? 32'(NUM_BINS) : 32'(bins_in_use);
		idx_ext = 32'(req.read_index);
		neg_mag = 32'(0) - req.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req.valid && req.ready) begin
						entry_q.side   <= req.func ? req.read_negative : req.value[31];
						entry_q.weight <= req.weight;
						entry_q.idx    <= req.read_index;
						entry_q.bin    <= shb_pkg::MAX_BIN_BITS'(idx_ext);
						if (req.func) begin
							entry_q.op <= (idx_ext < 32'(NUM_BINS)) ? shb_pkg::OP_READ
								: shb_pkg::OP_READ_ZERO;
							state_q    <= F_PUSH;
						end else begin
							// magnitude; the most negative value wraps to 2^31
							mag_q   <= req.value[31] ? neg_mag : req.value;
							div_q   <= bin_width;
							rem_q   <= '0;
							quot_q  <= '0;
							step_q  <= '0;
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					rem_q  <= qbit ? (rem_sh - {1'b0, div_q}) : rem_sh;
					quot_q <= quot_nx;
					mag_q  <= {mag_q[shb_pkg::DIV_BITS-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(shb_pkg::DIV_BITS - 1)) begin
						// zero width divides to all ones and is dropped here
						entry_q.op  <= (quot_nx >= limit) ? shb_pkg::OP_DROP : shb_pkg::OP_ADD;
						entry_q.bin <= quot_nx[shb_pkg::MAX_BIN_BITS-1:0];
						entry_q.idx <= (quot_nx > 32'(shb_pkg::OUT_IDX_MAX))
							? 10'(shb_pkg::OUT_IDX_MAX) : quot_nx[9:0];
						state_q     <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/shb_queue.sv =====
module shb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  shb_pkg::qentry_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output shb_pkg::qentry_t  head
);
	shb_pkg::qentry_t ent_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hdl/shb_back.sv =====
module shb_back #(
	parameter int NUM_BINS   = shb_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = shb_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  shb_pkg::qentry_t  head,
	output logic              pop,
	output logic              clearing,
	shb_rsp_if.source         rsp
);
	localparam int BIN_W = $clog2(NUM_BINS);
	// each bank spans a full power-of-two address range
	localparam int DEPTH = 2 * (1 << BIN_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int SUM_W = (COUNT_BITS > 16) ? COUNT_BITS + 1 : 17;
	localparam logic [SUM_W-1:0] CMAX = (SUM_W'(1) << COUNT_BITS) - SUM_W'(1);

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPD} bstate_t;

	bstate_t              state_q;
	logic [AW-1:0]        clr_q;
	shb_pkg::qentry_t     cur_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [31:0]          out_count_q;
	logic                 out_side_q;
	logic [9:0]           out_idx_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [COUNT_BITS-1:0] rdata;
	logic [SUM_W-1:0]     sum;
	logic [COUNT_BITS-1:0] sat;
	logic [63:0]          sat_ext;
	logic [63:0]          rd_ext;

	shb_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign clearing  = (state_q == B_CLEAR);
	assign pop       = (state_q == B_IDLE) && head_valid && !out_valid_q;
	assign raddr     = {head.side, head.bin[BIN_W-1:0]};

	// saturating add of the weight
	always_comb begin
		sum     = SUM_W'(rdata) + SUM_W'(cur_q.weight);
		sat     = (sum > CMAX) ? COUNT_BITS'(CMAX) : sum[COUNT_BITS-1:0];
		sat_ext = 64'(sat);
		rd_ext  = 64'(rdata);
		we      = clearing || ((state_q == B_UPD) && (cur_q.op == shb_pkg::OP_ADD));
		waddr   = clearing ? clr_q : {cur_q.side, cur_q.bin[BIN_W-1:0]};
		wdata   = clearing ? '0 : sat;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.count     = out_count_q;
	assign rsp.side      = out_side_q;
	assign rsp.bin_index = out_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						cur_q      <= head;
						out_side_q <= head.side;
						out_idx_q  <= head.idx;
						if (head.op == shb_pkg::OP_DROP) begin
							out_status_q <= shb_pkg::ST_DROPPED;
							out_count_q  <= '0;
							out_valid_q  <= 1'b1;
						end else if (head.op == shb_pkg::OP_READ_ZERO) begin
							out_status_q <= shb_pkg::ST_READ;
							out_count_q  <= '0;
							out_valid_q  <= 1'b1;
						end else begin
							state_q <= B_UPD;
						end
					end
				end
				B_UPD: begin
					// counter read data is here; write back for an add and report
					if (cur_q.op == shb_pkg::OP_ADD) begin
						out_status_q <= shb_pkg::ST_COUNTED;
						out_count_q  <= sat_ext[31:0];
					end else begin
						out_status_q <= shb_pkg::ST_READ;
						out_count_q  <= rd_ext[31:0];
					end
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/signed_histogram_binner.sv =====
// Channel  Dir  Payload
// req      in   func, value, weight, read_negative, read_index
// rsp      out  status, count, side, bin_index
// apb      in   bin_width at 0x0, bins_in_use at 0x4
//
// An add gets its bin index from a 32-step restoring divider in the front,
// one quotient bit per cycle. For an add the back does a read-modify-write
// on the counter RAM, reading as it pops the entry and writing back in the
// update state; a two-entry queue sits between front and back.
// After reset a clearing pass writes all 2*2^clog2(NUM_BINS) counters, one per
// cycle; req.ready stays low until it ends. A stalled rsp holds its output
// register while the front keeps dividing until the queue fills.
module signed_histogram_binner #(
	parameter int NUM_BINS   = shb_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = shb_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	shb_req_if.sink     req,
	shb_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic             clearing;
	logic             q_push;
	shb_pkg::qentry_t q_push_data;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	shb_pkg::qentry_t q_head;
	logic [31:0]      bin_width_q;
	logic [10:0]      bins_in_use_q;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == shb_pkg::REG_BINS_IN_USE) ? 32'(bins_in_use_q) : bin_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q   <= 32'd65536;
			bins_in_use_q <= 11'd1024;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == shb_pkg::REG_BIN_WIDTH) begin
				bin_width_q <= pwdata;
			end else begin
				bins_in_use_q <= pwdata[10:0];
			end
		end
	end

	shb_front #(.NUM_BINS(NUM_BINS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.clearing    (clearing),
		.bin_width   (bin_width_q),
		.bins_in_use (bins_in_use_q),
		.push        (q_push),
		.push_data   (q_push_data),
		.full        (q_full)
	);

	shb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	shb_back #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.clearing   (clearing),
		.rsp        (rsp)
	);

	// no transaction taken while counters are being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready) else $error("req accepted during clear");

	// queue never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");

	// dropped samples report a zero count
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == shb_pkg::ST_DROPPED) |-> (rsp.count == 32'd0))
		else $error("dropped sample with nonzero count");

endmodule
